FILE: rtl/bpa_pkg.sv
// Shared types and codes of the buddy page allocator.
`default_nettype none
package bpa_pkg;

	localparam int FRAME_PORT_W = 10;
	localparam int ORDER_PORT_W = 3;
	localparam int FRAME_MAX_W  = 16;

	localparam logic       OP_ALLOC = 1'b0;
	localparam logic       OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_NOMEM   = 2'd2;

	localparam logic       CFG_BASE_INDEX = 1'b0;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_SCAN,
		ST_A_SPLIT,
		ST_F_RD,
		ST_F_CHK,
		ST_F_LOOP,
		ST_F_BCHK,
		ST_F_MRD,
		ST_F_MWR,
		ST_UN_RD,
		ST_UN_DEC,
		ST_UN_RDA,
		ST_UN_WRA,
		ST_UN_RDB,
		ST_UN_WRB,
		ST_AP_WR,
		ST_AP_RDT,
		ST_AP_WRT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [FRAME_MAX_W-1:0] frame;
		logic [2:0]             order;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: register port, core and result register.
// One request at a time; the frame table has a single read and a single write port.
// Allocate: scans the orders upward, unlinks the block found, then splits it down level by level.
// Free: checks the frame, merges with a free buddy level by level, then pushes the block and emits.
// Results wait in an output register; the next request is taken as soon as it is loaded.
// After reset the frame table is loaded entry by entry while requests are stalled.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int FRAME_COUNT     = 1024,
	parameter int TOP_ORDER       = 6,
	parameter int PAGE_SHIFT_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    op,
	input  wire logic [ORDER_PORT_W-1:0] req_order,
	input  wire logic [FRAME_PORT_W-1:0] free_frame,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [1:0]              status,
	output logic      [FRAME_PORT_W-1:0] frame,
	output logic      [ORDER_PORT_W-1:0] block_order,
	output logic      [31:0]             address
);

	logic [31:0] base_q;
	logic        busy, res_valid, res_take, out_valid_q;
	res_t        res;
	logic [1:0]  status_q;
	logic [FRAME_PORT_W-1:0] frame_q;
	logic [ORDER_PORT_W-1:0] order_q;
	logic [31:0] address_q;

	// The single register decodes on the word index, so low byte bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_BASE_INDEX) ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_BASE_INDEX) begin
			base_q <= pwdata;
		end
	end

	bpa_core #(
		.FRAME_COUNT(FRAME_COUNT),
		.TOP_ORDER  (TOP_ORDER)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(in_valid),
		.req_op   (op),
		.req_order(req_order),
		.req_frame(free_frame),
		.busy     (busy),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take)
	);

	assign in_stall = busy;

	// The output slot is free when empty or being emptied this cycle.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// Address is formed here so the core never carries the base register.
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			status_q  <= res.status;
			frame_q   <= FRAME_PORT_W'(res.frame);
			order_q   <= res.order;
			address_q <= (res.status == STATUS_OK)
				? base_q + (32'(res.frame) << PAGE_SHIFT_BITS) : 32'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame       = frame_q;
	assign block_order = order_q;
	assign address     = address_q;

endmodule
`default_nettype wire

FILE: rtl/bpa_core.sv
// Sequencer and frame table of the buddy page allocator.
`default_nettype none
module bpa_core import bpa_pkg::*; #(
	parameter int FRAME_COUNT = 1024,
	parameter int TOP_ORDER   = 6
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	input  wire logic                    req_op,
	input  wire logic [ORDER_PORT_W-1:0] req_order,
	input  wire logic [FRAME_PORT_W-1:0] req_frame,
	output logic                         busy,
	output logic                         res_valid,
	output res_t                         res,
	input  wire logic                    res_take
);

	localparam int FW         = $clog2(FRAME_COUNT);
	localparam int OW         = $clog2(TOP_ORDER + 2);
	localparam int CW         = FW + 1;
	localparam int NL         = TOP_ORDER + 1;
	localparam int BLK        = 1 << TOP_ORDER;
	localparam int NBLK       = FRAME_COUNT >> TOP_ORDER;
	localparam int LAST       = (NBLK > 0) ? (NBLK - 1) * BLK : 0;
	localparam int ORDER_NONE = TOP_ORDER + 1;
	localparam int WW         = 1 + OW + 2 * FW;

	state_t state_q, nxt;

	logic [OW-1:0] i_q, want_q, o_q, tgt_o_q;
	logic          op_q, mid_q, a_next_q;
	logic [FW-1:0] f_q, t_q, tgt_f_q, nx_q, pv_q, a_addr_q, a_val_q, old_tail_q, init_q;
	res_t          res_q;

	logic [FW-1:0] head_q [NL];
	logic [FW-1:0] tail_q [NL];
	logic [CW-1:0] cnt_q  [NL];

	logic [WW-1:0] mem [FRAME_COUNT];
	logic [WW-1:0] rd_q;
	logic          mem_re, mem_we;
	logic [FW-1:0] mem_ra, mem_wa;
	logic [WW-1:0] mem_wd;

	logic          rd_free;
	logic [OW-1:0] rd_ord;
	logic [FW-1:0] rd_next, rd_prev;
	assign rd_free = rd_q[WW-1];
	assign rd_ord  = rd_q[WW-2 -: OW];
	assign rd_next = rd_q[2*FW-1:FW];
	assign rd_prev = rd_q[FW-1:0];

	logic [OW-1:0] lidx;
	logic [FW-1:0] l_head, l_tail;
	logic [CW-1:0] l_cnt;
	logic          l_empty, is_head, is_tail;
	assign lidx    = (state_q == ST_A_SCAN) ? i_q : tgt_o_q;
	assign l_head  = head_q[lidx];
	assign l_tail  = tail_q[lidx];
	assign l_cnt   = cnt_q[lidx];
	assign l_empty = (l_cnt == '0);
	assign is_head = (l_head == tgt_f_q);
	assign is_tail = (l_tail == tgt_f_q);

	logic [31:0]   bud32, split32;
	logic [OW-1:0] split_o;
	logic [FW-1:0] merged_f;
	logic          bud_ok, split_ok, loop_go, ord_bad, req_bad, frame_bad;
	assign bud32     = 32'(f_q) ^ (32'd1 << o_q);
	assign bud_ok    = bud32 < 32'(FRAME_COUNT);
	assign loop_go   = (32'(o_q) < 32'(TOP_ORDER)) && bud_ok;
	assign split_o   = i_q - OW'(1);
	assign split32   = 32'(t_q) ^ (32'd1 << split_o);
	assign split_ok  = split32 < 32'(FRAME_COUNT);
	assign merged_f  = f_q & ~(FW'(1) << o_q);
	assign ord_bad   = rd_free || (32'(rd_ord) > 32'(TOP_ORDER));
	assign req_bad   = 32'(req_order) > 32'(TOP_ORDER);
	assign frame_bad = 32'(req_frame) >= 32'(FRAME_COUNT);

	// Power-on contents of one frame entry: top-order heads chained in order.
	logic          init_head;
	logic [FW-1:0] init_next, init_prev;
	logic [WW-1:0] init_word;
	assign init_head = (NBLK > 0) && ((32'(init_q) & 32'(BLK - 1)) == 32'd0)
		&& (32'(init_q) <= 32'(LAST));
	assign init_next = (32'(init_q) == 32'(LAST)) ? init_q : FW'(32'(init_q) + 32'(BLK));
	assign init_prev = (init_q == '0) ? '0 : FW'(32'(init_q) - 32'(BLK));
	assign init_word = init_head ? {1'b1, OW'(TOP_ORDER), init_next, init_prev}
		: {1'b1, OW'(ORDER_NONE), {FW{1'b0}}, {FW{1'b0}}};

	state_t un_ret, ap_ret;
	assign un_ret = (op_q == OP_ALLOC) ? ST_A_SPLIT : ST_F_MRD;
	assign ap_ret = (op_q == OP_ALLOC) ? ST_A_SPLIT : ST_EMIT;

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt    = state_q;
		mem_re = 1'b0;
		mem_ra = tgt_f_q;
		mem_we = 1'b0;
		mem_wa = tgt_f_q;
		mem_wd = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = init_q;
				mem_wd = init_word;
				if (init_q == FW'(FRAME_COUNT - 1)) nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req_op == OP_ALLOC) nxt = req_bad ? ST_EMIT : ST_A_SCAN;
					else nxt = frame_bad ? ST_EMIT : ST_F_RD;
				end
			end
			ST_A_SCAN: begin
				if (!l_empty) nxt = ST_UN_RD;
				else if (i_q == OW'(TOP_ORDER)) nxt = ST_EMIT;
			end
			ST_A_SPLIT: begin
				if (i_q > want_q) begin
					if (split_ok) nxt = ST_AP_WR;
				end else begin
					nxt = ST_EMIT;
				end
			end
			ST_F_RD: begin
				mem_re = 1'b1;
				mem_ra = f_q;
				nxt    = ST_F_CHK;
			end
			ST_F_CHK: nxt = ord_bad ? ST_EMIT : ST_F_LOOP;
			ST_F_LOOP: begin
				if (loop_go) begin
					mem_re = 1'b1;
					mem_ra = FW'(bud32);
					nxt    = ST_F_BCHK;
				end else begin
					nxt = ST_AP_WR;
				end
			end
			ST_F_BCHK: begin
				if (rd_ord != o_q || !rd_free) nxt = ST_AP_WR;
				else nxt = ST_UN_RD;
			end
			ST_F_MRD: begin
				mem_re = 1'b1;
				mem_ra = merged_f;
				nxt    = ST_F_MWR;
			end
			ST_F_MWR: begin
				mem_we = 1'b1;
				mem_wa = f_q;
				mem_wd = {rd_free, o_q, rd_next, rd_prev};
				nxt    = ST_F_LOOP;
			end
			ST_UN_RD: begin
				mem_re = 1'b1;
				nxt    = ST_UN_DEC;
			end
			ST_UN_DEC: begin
				mem_we = 1'b1;
				mem_wd = {1'b0, (op_q == OP_ALLOC) ? want_q : rd_ord, rd_next, rd_prev};
				nxt    = (is_head && is_tail) ? un_ret : ST_UN_RDA;
			end
			ST_UN_RDA: begin
				mem_re = 1'b1;
				mem_ra = a_addr_q;
				nxt    = ST_UN_WRA;
			end
			ST_UN_WRA: begin
				mem_we = 1'b1;
				mem_wa = a_addr_q;
				mem_wd = a_next_q ? {rd_free, rd_ord, a_val_q, rd_prev}
					: {rd_free, rd_ord, rd_next, a_val_q};
				nxt    = mid_q ? ST_UN_RDB : un_ret;
			end
			ST_UN_RDB: begin
				mem_re = 1'b1;
				mem_ra = nx_q;
				nxt    = ST_UN_WRB;
			end
			ST_UN_WRB: begin
				mem_we = 1'b1;
				mem_wa = nx_q;
				mem_wd = {rd_free, rd_ord, rd_next, pv_q};
				nxt    = un_ret;
			end
			ST_AP_WR: begin
				mem_we = 1'b1;
				mem_wd = {1'b1, tgt_o_q, tgt_f_q, l_empty ? tgt_f_q : l_tail};
				nxt    = l_empty ? ap_ret : ST_AP_RDT;
			end
			ST_AP_RDT: begin
				mem_re = 1'b1;
				mem_ra = old_tail_q;
				nxt    = ST_AP_WRT;
			end
			ST_AP_WRT: begin
				mem_we = 1'b1;
				mem_wa = old_tail_q;
				mem_wd = {rd_free, rd_ord, tgt_f_q, rd_prev};
				nxt    = ap_ret;
			end
			ST_EMIT: begin
				if (res_take) nxt = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	// Frame table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			for (int k = 0; k < NL; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= (k == TOP_ORDER) ? FW'(LAST) : '0;
				cnt_q[k]  <= (k == TOP_ORDER) ? CW'(NBLK) : '0;
			end
		end else begin
			case (state_q)
				ST_INIT: init_q <= init_q + FW'(1);
				ST_UN_DEC: begin
					if (is_head && is_tail) begin
						head_q[lidx] <= '0;
						tail_q[lidx] <= '0;
					end else if (is_head) begin
						head_q[lidx] <= rd_next;
					end else if (is_tail) begin
						tail_q[lidx] <= rd_prev;
					end
					if (!l_empty) cnt_q[lidx] <= l_cnt - CW'(1);
				end
				ST_AP_WR: begin
					if (l_empty) head_q[lidx] <= tgt_f_q;
					tail_q[lidx] <= tgt_f_q;
					cnt_q[lidx]  <= l_cnt + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q   <= req_op;
				want_q <= OW'(req_order);
				i_q    <= OW'(req_order);
				f_q    <= FW'(req_frame);
				res_q  <= '{STATUS_INVALID, '0, '0};
			end
			ST_A_SCAN: begin
				if (!l_empty) begin
					tgt_f_q <= l_head;
					tgt_o_q <= i_q;
					t_q     <= l_head;
				end else if (i_q == OW'(TOP_ORDER)) begin
					res_q <= '{STATUS_NOMEM, '0, '0};
				end else begin
					i_q <= i_q + OW'(1);
				end
			end
			ST_A_SPLIT: begin
				if (i_q > want_q) begin
					i_q     <= split_o;
					tgt_f_q <= FW'(split32);
					tgt_o_q <= split_o;
				end else begin
					res_q <= '{STATUS_OK, FRAME_MAX_W'(t_q), 3'(want_q)};
				end
			end
			ST_F_CHK: o_q <= rd_ord;
			ST_F_LOOP: begin
				if (loop_go) begin
					tgt_f_q <= FW'(bud32);
				end else begin
					tgt_f_q <= f_q;
				end
				tgt_o_q <= o_q;
			end
			ST_F_BCHK: begin
				if (rd_ord != o_q || !rd_free) begin
					tgt_f_q <= f_q;
					tgt_o_q <= o_q;
				end
			end
			ST_F_MRD: begin
				f_q <= merged_f;
				o_q <= o_q + OW'(1);
			end
			ST_UN_DEC: begin
				nx_q  <= rd_next;
				pv_q  <= rd_prev;
				mid_q <= !is_head && !is_tail;
				if (is_head) begin
					a_addr_q <= rd_next;
					a_next_q <= 1'b0;
					a_val_q  <= rd_next;
				end else if (is_tail) begin
					a_addr_q <= rd_prev;
					a_next_q <= 1'b1;
					a_val_q  <= rd_prev;
				end else begin
					a_addr_q <= rd_prev;
					a_next_q <= 1'b1;
					a_val_q  <= rd_next;
				end
			end
			ST_AP_WR: begin
				old_tail_q <= l_tail;
				if (op_q == OP_FREE) res_q <= '{STATUS_OK, FRAME_MAX_W'(f_q), 3'(o_q)};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/bpa_checker.sv
// Port-level checks of the buddy page allocator and their binding.
`default_nettype none
module bpa_checker import bpa_pkg::*; #(
	parameter int TOP_ORDER   = 6
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic [1:0]              status,
	input wire logic [FRAME_PORT_W-1:0] frame,
	input wire logic [ORDER_PORT_W-1:0] block_order,
	input wire logic [31:0]             address
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({status, frame, block_order, address}))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> frame == '0 && block_order == '0 && address == '0)
		else $error("failed request carries nonzero fields");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> 32'(block_order) <= 32'(TOP_ORDER))
		else $error("block order beyond top order");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still running");

endmodule

bind buddy_page_allocator bpa_checker #(
	.TOP_ORDER  (TOP_ORDER)
) u_bpa_checker (.*);
`default_nettype wire
